/* hw/rtl/lcar_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcar_pkg: load-cell converter reader shared definitions
// Widths, request codes and the microcode store of the reader sequencer.
// ----------------------------------------------------------------------------
package lcar_pkg;

    // sample and request geometry
    localparam int SAMPLE_BITS = 24;
    localparam int MAX_COUNT   = 127;
    localparam int B_PULSES    = 2;
    localparam int A_PULSES_LO = 1;   // gain 128
    localparam int A_PULSES_HI = 3;   // gain 64

    localparam int FUNC_W    = 2;
    localparam int COUNT_W   = 7;
    localparam int PULSE_W   = 2;
    localparam int SUM_W     = 32;
    localparam int RESULT_W  = SAMPLE_BITS + 1;
    localparam int AVG_W     = SUM_W + 1;
    localparam int DIFF_W    = AVG_W + 1;
    localparam int BIT_CNT_W = $clog2(SAMPLE_BITS);
    localparam int DIV_CNT_W = $clog2(SUM_W);

    // request codes
    localparam logic [FUNC_W-1:0] FUNC_TICK    = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FUNC_MEASURE = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FUNC_TARE    = FUNC_W'(2);

    // microprogram steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_BIT_HI,
        S_BIT_LO,
        S_PULSE_HI,
        S_PULSE_LO,
        S_CONV_END,
        S_DUMMY,
        S_ACC,
        S_DIV_INIT,
        S_DIV_ITER,
        S_DIV_SIGN,
        S_FINISH
    } t_step;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_REQ,
        OP_CLR_SHIFT,
        OP_SHIFT,
        OP_BIT_INC,
        OP_PULSE_DEC,
        OP_CLR_DUMMY,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_ITER,
        OP_DIV_SIGN,
        OP_FINISH
    } t_op;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_REQ,
        C_DOUT_LOW,
        C_LAST_BIT,
        C_PULSE_MORE,
        C_DUMMY,
        C_READS_MORE,
        C_DIV_MORE
    } t_cond;

    // one control word
    typedef struct packed {
        logic  take;   // step consumes one tick transaction
        logic  sck;    // serial clock level for that tick
        logic  done;   // step presents the request result
        t_op   op;
        t_cond cond;
        t_step jump;   // taken when cond holds
        t_step next;   // fall-through
    } t_uword;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        w = '{take: 1'b0, sck: 1'b0, done: 1'b0, op: OP_NOP, cond: C_NEVER,
              jump: S_IDLE, next: S_IDLE};
        unique case (s)
            S_IDLE:     w = '{1'b1, 1'b0, 1'b0, OP_REQ,       C_REQ,
                              S_WAIT,     S_IDLE};
            S_WAIT:     w = '{1'b1, 1'b0, 1'b0, OP_CLR_SHIFT, C_DOUT_LOW,
                              S_BIT_HI,   S_WAIT};
            S_BIT_HI:   w = '{1'b1, 1'b1, 1'b0, OP_SHIFT,     C_NEVER,
                              S_BIT_LO,   S_BIT_LO};
            S_BIT_LO:   w = '{1'b1, 1'b0, 1'b0, OP_BIT_INC,   C_LAST_BIT,
                              S_PULSE_HI, S_BIT_HI};
            S_PULSE_HI: w = '{1'b1, 1'b1, 1'b0, OP_NOP,       C_NEVER,
                              S_PULSE_LO, S_PULSE_LO};
            S_PULSE_LO: w = '{1'b1, 1'b0, 1'b0, OP_PULSE_DEC, C_PULSE_MORE,
                              S_PULSE_HI, S_CONV_END};
            S_CONV_END: w = '{1'b0, 1'b0, 1'b0, OP_NOP,       C_DUMMY,
                              S_DUMMY,    S_ACC};
            S_DUMMY:    w = '{1'b0, 1'b0, 1'b0, OP_CLR_DUMMY, C_NEVER,
                              S_WAIT,     S_WAIT};
            S_ACC:      w = '{1'b0, 1'b0, 1'b0, OP_ACC,       C_READS_MORE,
                              S_WAIT,     S_DIV_INIT};
            S_DIV_INIT: w = '{1'b0, 1'b0, 1'b0, OP_DIV_INIT,  C_NEVER,
                              S_DIV_ITER, S_DIV_ITER};
            S_DIV_ITER: w = '{1'b0, 1'b0, 1'b0, OP_DIV_ITER,  C_DIV_MORE,
                              S_DIV_ITER, S_DIV_SIGN};
            S_DIV_SIGN: w = '{1'b0, 1'b0, 1'b0, OP_DIV_SIGN,  C_NEVER,
                              S_FINISH,   S_FINISH};
            S_FINISH:   w = '{1'b0, 1'b0, 1'b1, OP_FINISH,    C_NEVER,
                              S_IDLE,     S_IDLE};
            default:    w = '{1'b0, 1'b0, 1'b0, OP_NOP,       C_NEVER,
                              S_IDLE,     S_IDLE};
        endcase
        return w;
    endfunction

endpackage : lcar_pkg
`default_nettype wire

/* hw/rtl/load_cell_adc_reader.sv */
`timescale 1ns / 1ps
`default_nettype none
// A tick transaction normally yields its result in the cycle after acceptance. The
// last pulse tick of a conversion yields it after the conversion wrap-up steps; the
// last pulse tick of a request after accumulate, 32-step restoring divide,
// sign fix and offset/saturate. Throughput: one tick per cycle on all other ticks
// while unstalled, set by the single microcode sequencer that also runs the divider.
// Reset (i_rst_n low, synchronous): idle, offsets zero, channel A gain select 1.
// ----------------------------------------------------------------------------
// load_cell_adc_reader: two-wire load-cell converter reader
// Microcoded sequencer that bit-bangs the converter serial clock, averages
// conversions and applies per-channel tare offsets.
// ----------------------------------------------------------------------------
module load_cell_adc_reader (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // configuration write channel
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire                                 i_gain_a_select,
    // tick input channel
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  [lcar_pkg::FUNC_W-1:0]         i_func,
    input  wire                                 i_dout_level,
    input  wire                                 i_chan,
    input  wire  [lcar_pkg::COUNT_W-1:0]        i_sample_count,
    // result output channel
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_sck_level,
    output logic                                o_busy_res,
    output logic                                o_done_res,
    output logic signed [lcar_pkg::RESULT_W-1:0] o_result_value
);
    import lcar_pkg::*;

    localparam logic signed [AVG_W-1:0] OFF_MIN = -(AVG_W'(1) <<< (SAMPLE_BITS - 1));
    localparam logic signed [AVG_W-1:0] OFF_MAX = (AVG_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [DIFF_W-1:0] RES_MIN = -(DIFF_W'(1) <<< SAMPLE_BITS);
    localparam logic signed [DIFF_W-1:0] RES_MAX = (DIFF_W'(1) <<< SAMPLE_BITS) - 1;

    // ---- sequencer state ----
    t_step r_step;
    t_step n_step;
    logic  r_tick_sck;      // clock level of the last consumed tick

    // ---- datapath registers ----
    logic                          r_gain_a;
    logic                          r_kind;        // 1 = tare
    logic                          r_chan;
    logic                          r_dummy;
    logic [BIT_CNT_W-1:0]          r_bit_cnt;
    logic [PULSE_W-1:0]            r_pulse_cnt;
    logic [SAMPLE_BITS-1:0]        r_shift;
    logic [COUNT_W-1:0]            r_reads_left;
    logic [COUNT_W-1:0]            r_divisor;
    logic [SUM_W-1:0]              r_sum;
    logic [SUM_W-1:0]              r_quo;
    logic [COUNT_W-1:0]            r_rem;
    logic [DIV_CNT_W-1:0]          r_div_cnt;
    logic                          r_neg;
    logic signed [AVG_W-1:0]       r_avg;
    logic signed [SAMPLE_BITS-1:0] r_offset [2];

    // ---- output register ----
    logic                          r_out_valid;
    logic                          r_out_sck;
    logic                          r_out_busy;
    logic                          r_out_done;
    logic signed [RESULT_W-1:0]    r_out_result;

    // ---- decode ----
    t_uword uw;
    t_uword uw_next;
    logic   out_free;
    logic   in_accept;
    logic   adv;
    logic   emit;
    logic   is_req;
    logic   cond_hit;

    logic [COUNT_W-1:0]            req_cnt;
    logic [PULSE_W-1:0]            pulse_load;
    logic [SUM_W-1:0]              sample_ext;
    logic [COUNT_W:0]              div_sh;
    logic                          div_bit;
    logic signed [SAMPLE_BITS-1:0] cur_off;
    logic signed [DIFF_W-1:0]      diff;
    logic signed [SAMPLE_BITS-1:0] tare_val;
    logic signed [RESULT_W-1:0]    meas_val;
    logic signed [RESULT_W-1:0]    fin_val;

    assign uw        = ucode(r_step);
    assign out_free  = !r_out_valid || !i_stall;
    assign o_stall   = !(uw.take && out_free);
    assign in_accept = i_valid && !o_stall;
    // internal steps run whenever the output register can take a result
    assign adv       = uw.take ? in_accept : out_free;

    assign is_req = (i_func == FUNC_MEASURE) || (i_func == FUNC_TARE);

    always_comb begin
        unique case (uw.cond)
            C_NEVER:      cond_hit = 1'b0;
            C_REQ:        cond_hit = is_req;
            C_DOUT_LOW:   cond_hit = !i_dout_level;
            C_LAST_BIT:   cond_hit = (r_bit_cnt == BIT_CNT_W'(SAMPLE_BITS - 1));
            C_PULSE_MORE: cond_hit = (r_pulse_cnt > PULSE_W'(1));
            C_DUMMY:      cond_hit = r_dummy;
            C_READS_MORE: cond_hit = (r_reads_left > COUNT_W'(1));
            C_DIV_MORE:   cond_hit = (r_div_cnt != '0);
            default:      cond_hit = 1'b0;
        endcase
    end

    assign n_step  = cond_hit ? uw.jump : uw.next;
    assign uw_next = ucode(n_step);
    // a tick's result leaves once the program is back at a tick-consuming step
    assign emit    = adv && uw_next.take;

    // request count: zero means one, saturate at the maximum
    always_comb begin
        if (i_sample_count == '0) begin
            req_cnt = COUNT_W'(1);
        end else if (i_sample_count > COUNT_W'(MAX_COUNT)) begin
            req_cnt = COUNT_W'(MAX_COUNT);
        end else begin
            req_cnt = i_sample_count;
        end
    end

    assign pulse_load = r_chan   ? PULSE_W'(B_PULSES) :
                        r_gain_a ? PULSE_W'(A_PULSES_HI) : PULSE_W'(A_PULSES_LO);

    assign sample_ext = {{(SUM_W - SAMPLE_BITS){r_shift[SAMPLE_BITS-1]}}, r_shift};

    // restoring divide step
    assign div_sh  = {r_rem, r_quo[SUM_W-1]};
    assign div_bit = (div_sh >= {1'b0, r_divisor});

    // final result: tare saturates to sample range, measure to result range
    assign cur_off = r_offset[r_chan];
    assign diff    = {r_avg[AVG_W-1], r_avg} - DIFF_W'(cur_off);

    always_comb begin
        if (r_avg < OFF_MIN) begin
            tare_val = OFF_MIN[SAMPLE_BITS-1:0];
        end else if (r_avg > OFF_MAX) begin
            tare_val = OFF_MAX[SAMPLE_BITS-1:0];
        end else begin
            tare_val = r_avg[SAMPLE_BITS-1:0];
        end
        if (diff < RES_MIN) begin
            meas_val = RES_MIN[RESULT_W-1:0];
        end else if (diff > RES_MAX) begin
            meas_val = RES_MAX[RESULT_W-1:0];
        end else begin
            meas_val = diff[RESULT_W-1:0];
        end
        fin_val = r_kind ? RESULT_W'(tare_val) : meas_val;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_tick_sck  <= 1'b0;
            r_gain_a    <= 1'b1;
            r_dummy     <= 1'b0;
            r_offset[0] <= '0;
            r_offset[1] <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_gain_a <= i_gain_a_select;
            end

            if (r_out_valid && !i_stall && !emit) begin
                r_out_valid <= 1'b0;
            end

            if (adv) begin
                r_step <= n_step;
                if (uw.take) begin
                    r_tick_sck <= uw.sck;
                end

                unique case (uw.op)
                    OP_NOP: begin
                    end
                    OP_REQ: begin
                        if (is_req) begin
                            r_kind       <= (i_func == FUNC_TARE);
                            r_chan       <= i_chan;
                            r_reads_left <= req_cnt;
                            r_divisor    <= req_cnt;
                            r_sum        <= '0;
                            r_dummy      <= 1'b1;
                        end
                    end
                    OP_CLR_SHIFT: begin
                        r_bit_cnt <= '0;
                        r_shift   <= '0;
                    end
                    OP_SHIFT: begin
                        r_shift <= {r_shift[SAMPLE_BITS-2:0], i_dout_level};
                    end
                    OP_BIT_INC: begin
                        r_bit_cnt   <= r_bit_cnt + BIT_CNT_W'(1);
                        r_pulse_cnt <= pulse_load;
                    end
                    OP_PULSE_DEC: begin
                        if (r_pulse_cnt != '0) begin
                            r_pulse_cnt <= r_pulse_cnt - PULSE_W'(1);
                        end
                    end
                    OP_CLR_DUMMY: begin
                        r_dummy <= 1'b0;
                    end
                    OP_ACC: begin
                        r_sum <= r_sum + sample_ext;
                        if (r_reads_left != '0) begin
                            r_reads_left <= r_reads_left - COUNT_W'(1);
                        end
                    end
                    OP_DIV_INIT: begin
                        r_neg     <= r_sum[SUM_W-1];
                        r_quo     <= r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
                        r_rem     <= '0;
                        r_div_cnt <= DIV_CNT_W'(SUM_W - 1);
                    end
                    OP_DIV_ITER: begin
                        r_rem     <= div_bit ? COUNT_W'(div_sh - {1'b0, r_divisor})
                                             : div_sh[COUNT_W-1:0];
                        r_quo     <= {r_quo[SUM_W-2:0], div_bit};
                        r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
                    end
                    OP_DIV_SIGN: begin
                        r_avg <= r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
                    end
                    OP_FINISH: begin
                        if (r_kind) begin
                            r_offset[r_chan] <= tare_val;
                        end
                    end
                    default: begin
                    end
                endcase

                if (emit) begin
                    r_out_valid  <= 1'b1;
                    r_out_sck    <= uw.take ? uw.sck : r_tick_sck;
                    r_out_busy   <= (n_step != S_IDLE);
                    r_out_done   <= uw.done;
                    r_out_result <= uw.done ? fin_val : '0;
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_sck_level    = r_out_sck;
    assign o_busy_res     = r_out_busy;
    assign o_done_res     = r_out_done;
    assign o_result_value = r_out_result;

endmodule : load_cell_adc_reader
`default_nettype wire

/* hw/rtl/lcar_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcar_checker: port-level checks for the load-cell reader
// Watches the result channel for consistency of status and data.
// ----------------------------------------------------------------------------
module lcar_checker (
    input wire                                  i_clk,
    input wire                                  i_rst_n,
    input wire                                  o_valid,
    input wire                                  i_stall,
    input wire                                  o_sck_level,
    input wire                                  o_busy_res,
    input wire                                  o_done_res,
    input wire signed [lcar_pkg::RESULT_W-1:0]  o_result_value
);
    import lcar_pkg::*;

    // a finished request leaves the reader idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done with busy set");

    // result data only on a done transaction
    a_result_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_done_res |-> o_result_value == '0)
        else $error("nonzero result without done");

    // serial clock only pulses inside a request
    a_sck_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sck_level |-> o_busy_res)
        else $error("sck high while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_done_res))
        else $error("stalled result changed");

endmodule : lcar_checker

bind load_cell_adc_reader lcar_checker u_lcar_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_sck_level    (o_sck_level),
    .o_busy_res     (o_busy_res),
    .o_done_res     (o_done_res),
    .o_result_value (o_result_value)
);
`default_nettype wire
